// ----- hdl/ldpm_pkg.sv -----
// Shared types, constants and helper functions of the lens distortion point map.
// Used by ldpm_mulq, lens_distortion_point_map and its testbench; no dependencies.
`timescale 1ns / 1ps

package ldpm_pkg;

    // Widths of fixed-point values
    localparam int QW = 61;                 // signed Q.30 working value
    localparam int MW = QW - 1;             // magnitude of a working value
    localparam int HW = MW / 2;             // half magnitude, one partial operand
    localparam int PW = 2 * MW;             // full product width
    localparam int CW = 24;                 // pixel coordinate width
    localparam int NW = 64;                 // dividend width of the normaliser

    // Pipeline shape
    localparam int DIV_STEPS = NW;          // one quotient bit per stage
    localparam int LATENCY   = 96;          // input register to output register
    localparam int XY_DLY    = 18;          // normalised x, y to the second product layer
    localparam int XYP_DLY   = 14;          // x*y product to the second product layer
    localparam int T_DLY     = 12;          // tangential sums to the second product layer
    localparam int R2_DLY    = 8;           // r2 to the k1 product
    localparam int R4_DLY    = 4;           // r4 to the k2 product

    // Product shifts
    localparam logic [5:0] SH_Q30 = 6'd30;
    localparam logic [5:0] SH_COEF = 6'd24;
    localparam logic [5:0] SH_DBL = 6'd23;

    localparam logic signed [63:0] QLIM64  = 64'sh0FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ONE_Q30 = 64'sh0000_0000_4000_0000;
    localparam logic signed [63:0] OUT_MAX = 64'sd8388607;
    localparam logic signed [63:0] OUT_MIN = -64'sd8388608;
    localparam logic [MW-1:0]      QLIM_MAG = {MW{1'b1}};

    // Register map, index into the register list
    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_PRINCIPAL = 3'd2,
        REG_K1        = 3'd3,
        REG_K2        = 3'd4,
        REG_K3        = 3'd5,
        REG_P1        = 3'd6,
        REG_P2        = 3'd7
    } reg_idx_t;

    // One lane of the restoring divider: partial remainder and the word that
    // holds the unused dividend bits above and the quotient bits below
    typedef struct packed {
        logic [31:0]   rem;
        logic [NW-1:0] w;
        logic          neg;
    } div_lane_t;

    function automatic logic signed [63:0] ext64(input logic signed [QW-1:0] v);
        ext64 = 64'(v);
    endfunction

    // Saturate a sum to +-(2^60 - 1)
    function automatic logic signed [QW-1:0] sat_q(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > QLIM64) begin
            r = QLIM64;
        end else if (v < -QLIM64) begin
            r = -QLIM64;
        end
        sat_q = r[QW-1:0];
    endfunction

    // One restoring division step
    function automatic div_lane_t div_step(input div_lane_t d, input logic [31:0] f);
        div_lane_t  r;
        logic [32:0] t;
        logic        ge;
        t  = {d.rem, d.w[NW-1]};
        ge = (t >= {1'b0, f});
        r.rem = ge ? 32'(t - {1'b0, f}) : t[31:0];
        r.w   = {d.w[NW-2:0], ge};
        r.neg = d.neg;
        div_step = r;
    endfunction

endpackage

// ----- hdl/ldpm_mulq.sv -----
// Pipelined signed fixed-point multiplier: (a*b) >> shift, truncated toward zero,
// saturated to +-(2^60 - 1). Depends on ldpm_pkg.
`timescale 1ns / 1ps

module ldpm_mulq (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [ldpm_pkg::QW-1:0]   a,
    input  logic signed [ldpm_pkg::QW-1:0]   b,
    input  logic [5:0]                       shift,
    output logic signed [ldpm_pkg::QW-1:0]   p
);
    import ldpm_pkg::*;

    logic signed [QW-1:0] a_abs, b_abs;
    logic [MW-1:0]        ua_reg, ub_reg;
    logic [2:0]           neg_reg;
    logic [MW-1:0]        pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [PW-1:0]        sum_reg;
    logic [PW-1:0]        shifted;
    logic [MW-1:0]        mag;
    logic signed [QW-1:0] p_reg;

    // Magnitudes of the operands
    always_comb begin
        a_abs = a[QW-1] ? -a : a;
        b_abs = b[QW-1] ? -b : b;
    end

    // Stage 1: split sign and magnitude
    always_ff @(posedge aclk) begin
        if (en) begin
            ua_reg     <= a_abs[MW-1:0];
            ub_reg     <= b_abs[MW-1:0];
            neg_reg[0] <= a[QW-1] ^ b[QW-1];
            neg_reg[1] <= neg_reg[0];
            neg_reg[2] <= neg_reg[1];
        end
    end

    // Stage 2: four half-width partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            pp00_reg <= ua_reg[HW-1:0]  * ub_reg[HW-1:0];
            pp01_reg <= ua_reg[HW-1:0]  * ub_reg[MW-1:HW];
            pp10_reg <= ua_reg[MW-1:HW] * ub_reg[HW-1:0];
            pp11_reg <= ua_reg[MW-1:HW] * ub_reg[MW-1:HW];
        end
    end

    // Stage 3: combine the partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= {{MW{1'b0}}, pp00_reg}
                     + ({{MW{1'b0}}, pp01_reg} << HW)
                     + ({{MW{1'b0}}, pp10_reg} << HW)
                     + ({{MW{1'b0}}, pp11_reg} << MW);
        end
    end

    // Stage 4: shift, saturate, restore the sign
    always_comb begin
        shifted = sum_reg >> shift;
        mag     = (|shifted[PW-1:MW]) ? QLIM_MAG : shifted[MW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= neg_reg[2] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
        end
    end

    assign p = p_reg;

endmodule

// ----- hdl/lens_distortion_point_map.sv -----
// Top level of the lens distortion point map: register file, normaliser and
// distortion pipeline. Depends on ldpm_pkg and ldpm_mulq.
`timescale 1ns / 1ps

// Maps ideal pixel points to distorted pixel positions (five-coefficient
// radial and tangential lens model).
// Input channel s_*: one point per item, x in tdata[23:0], y in tdata[47:24],
// batch marker on tlast. Result channel m_*: distorted x and y in the same
// layout, the marker copied to tlast, and tuser set when either coordinate
// saturated.
// The APB port holds focal lengths, principal point and coefficients; write
// them only while no items are in flight.
// The pipeline has 96 register stages, from the input register to the output
// register. The depth is set mostly by the 64-stage restoring divider that
// normalises the point and by six layers of multipliers. One item is taken
// every cycle while the receiver does not stall the result channel.
// Reset clears all valid bits and loads the default registers (unit focal
// lengths, zero principal point and coefficients); s_tready stays low while
// reset is held. When the receiver holds tready low with a result waiting, the
// whole pipeline holds and s_tready falls in the same cycle; nothing is lost
// or repeated.
module lens_distortion_point_map (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // point_x [23:0], point_y [47:24]
    input  logic        s_tlast,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // distorted_x [23:0], distorted_y [47:24]
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // clipped [0]
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import ldpm_pkg::*;

    // Configuration registers
    logic [31:0] focal_x_reg, focal_y_reg;
    logic [63:0] principal_reg;
    logic [31:0] k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;
    reg_idx_t    widx;
    logic        wr_en;

    logic [31:0] fx, fy;
    logic [31:0] cx, cy;
    logic signed [QW-1:0] k1, k2, k3, p1, p2, fx_q, fy_q;

    // Pipeline control
    logic               en;
    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] last_reg;

    logic signed [CW-1:0] px_reg, py_reg;
    logic signed [33:0]   dx_reg, dy_reg;
    logic [32:0]          mx, my;
    div_lane_t            nx_reg, ny_reg;
    div_lane_t            divx_reg [DIV_STEPS];
    div_lane_t            divy_reg [DIV_STEPS];
    logic signed [QW-1:0] x_reg, y_reg;

    logic signed [QW-1:0] xx, yy, xy, r4, r6, k1r, k2r, k3r;
    logic signed [QW-1:0] r2_reg, xx_reg, yy_reg, tx_reg, ty_reg, rad_reg;
    logic signed [QW-1:0] x_dly_reg  [XY_DLY];
    logic signed [QW-1:0] y_dly_reg  [XY_DLY];
    logic signed [QW-1:0] xy_dly_reg [XYP_DLY];
    logic signed [QW-1:0] tx_dly_reg [T_DLY];
    logic signed [QW-1:0] ty_dly_reg [T_DLY];
    logic signed [QW-1:0] r2_dly_reg [R2_DLY];
    logic signed [QW-1:0] r4_dly_reg [R4_DLY];

    logic signed [QW-1:0] xrad, p1xy, p2tx, yrad, p1ty, p2xy;
    logic signed [QW-1:0] xd_reg, yd_reg, qx, qy;
    logic signed [63:0]   q8x, q8y;
    logic signed [CW-1:0] ox_reg, oy_reg;
    logic                 clip_reg;
    logic                 clip_x, clip_y;
    logic signed [CW-1:0] ox_next, oy_next;

    // APB register file
    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg   <= 32'h0001_0000;
            focal_y_reg   <= 32'h0001_0000;
            principal_reg <= '0;
            k1_reg        <= '0;
            k2_reg        <= '0;
            k3_reg        <= '0;
            p1_reg        <= '0;
            p2_reg        <= '0;
        end else if (wr_en) begin
            case (widx)
                REG_FOCAL_X:   focal_x_reg   <= pwdata[31:0];
                REG_FOCAL_Y:   focal_y_reg   <= pwdata[31:0];
                REG_PRINCIPAL: principal_reg <= pwdata;
                REG_K1:        k1_reg        <= pwdata[31:0];
                REG_K2:        k2_reg        <= pwdata[31:0];
                REG_K3:        k3_reg        <= pwdata[31:0];
                REG_P1:        p1_reg        <= pwdata[31:0];
                REG_P2:        p2_reg        <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            REG_FOCAL_X:   prdata = {32'b0, focal_x_reg};
            REG_FOCAL_Y:   prdata = {32'b0, focal_y_reg};
            REG_PRINCIPAL: prdata = principal_reg;
            REG_K1:        prdata = {32'b0, k1_reg};
            REG_K2:        prdata = {32'b0, k2_reg};
            REG_K3:        prdata = {32'b0, k3_reg};
            REG_P1:        prdata = {32'b0, p1_reg};
            REG_P2:        prdata = {32'b0, p2_reg};
            default:       prdata = '0;
        endcase
    end

    // Effective operands; a zero focal length counts as one LSB
    always_comb begin
        fx   = (focal_x_reg == 32'b0) ? 32'd1 : focal_x_reg;
        fy   = (focal_y_reg == 32'b0) ? 32'd1 : focal_y_reg;
        cx   = principal_reg[31:0];
        cy   = principal_reg[63:32];
        fx_q = signed'({{(QW-32){1'b0}}, fx});
        fy_q = signed'({{(QW-32){1'b0}}, fy});
        k1   = QW'(signed'(k1_reg));
        k2   = QW'(signed'(k2_reg));
        k3   = QW'(signed'(k3_reg));
        p1   = QW'(signed'(p1_reg));
        p2   = QW'(signed'(p2_reg));
    end

    // Advance everything unless a result waits on a stalled receiver
    assign en       = ~m_tvalid | m_tready;
    assign s_tready = en & aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LATENCY-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg <= {last_reg[LATENCY-2:0], s_tlast};
        end
    end

    // Input register, then offset from the principal point
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= s_tdata[CW-1:0];
            py_reg <= s_tdata[2*CW-1:CW];
            dx_reg <= signed'({{2{px_reg[CW-1]}}, px_reg, 8'b0}) - signed'({2'b0, cx});
            dy_reg <= signed'({{2{py_reg[CW-1]}}, py_reg, 8'b0}) - signed'({2'b0, cy});
        end
    end

    // Build the dividend |d|*2^30 + f/2
    always_comb begin
        mx = dx_reg[33] ? 33'(-dx_reg) : dx_reg[32:0];
        my = dy_reg[33] ? 33'(-dy_reg) : dy_reg[32:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg.rem <= '0;
            nx_reg.w   <= {1'b0, mx, 30'b0} + {33'b0, fx[31:1]};
            nx_reg.neg <= dx_reg[33];
            ny_reg.rem <= '0;
            ny_reg.w   <= {1'b0, my, 30'b0} + {33'b0, fy[31:1]};
            ny_reg.neg <= dy_reg[33];
        end
    end

    // Restoring divider, one quotient bit per stage
    always_ff @(posedge aclk) begin
        if (en) begin
            divx_reg[0] <= div_step(nx_reg, fx);
            divy_reg[0] <= div_step(ny_reg, fy);
            for (int i = 1; i < DIV_STEPS; i++) begin
                divx_reg[i] <= div_step(divx_reg[i-1], fx);
                divy_reg[i] <= div_step(divy_reg[i-1], fy);
            end
        end
    end

    // Saturate the quotient and apply the sign: normalised x, y
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= sat_q(divx_reg[DIV_STEPS-1].neg ? -signed'(divx_reg[DIV_STEPS-1].w)
                                                      : signed'(divx_reg[DIV_STEPS-1].w));
            y_reg <= sat_q(divy_reg[DIV_STEPS-1].neg ? -signed'(divy_reg[DIV_STEPS-1].w)
                                                      : signed'(divy_reg[DIV_STEPS-1].w));
        end
    end

    // First product layer: squares and cross term
    ldpm_mulq u_mul_xx (.aclk, .en, .a(x_reg), .b(x_reg), .shift(SH_Q30), .p(xx));
    ldpm_mulq u_mul_yy (.aclk, .en, .a(y_reg), .b(y_reg), .shift(SH_Q30), .p(yy));
    ldpm_mulq u_mul_xy (.aclk, .en, .a(x_reg), .b(y_reg), .shift(SH_Q30), .p(xy));

    // r2, then the tangential sums
    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg <= sat_q(ext64(xx) + ext64(yy));
            xx_reg <= xx;
            yy_reg <= yy;
            tx_reg <= sat_q(ext64(r2_reg) + (ext64(xx_reg) <<< 1));
            ty_reg <= sat_q(ext64(r2_reg) + (ext64(yy_reg) <<< 1));
        end
    end

    // Powers of r2
    ldpm_mulq u_mul_r4 (.aclk, .en, .a(r2_reg), .b(r2_reg), .shift(SH_Q30), .p(r4));
    ldpm_mulq u_mul_r6 (.aclk, .en, .a(r4), .b(r2_dly_reg[R4_DLY-1]), .shift(SH_Q30),
                        .p(r6));

    // Radial coefficient products, aligned to finish together
    ldpm_mulq u_mul_k1 (.aclk, .en, .a(k1), .b(r2_dly_reg[R2_DLY-1]), .shift(SH_COEF),
                        .p(k1r));
    ldpm_mulq u_mul_k2 (.aclk, .en, .a(k2), .b(r4_dly_reg[R4_DLY-1]), .shift(SH_COEF),
                        .p(k2r));
    ldpm_mulq u_mul_k3 (.aclk, .en, .a(k3), .b(r6), .shift(SH_COEF), .p(k3r));

    // Delay lines that hold operands until their product layer
    always_ff @(posedge aclk) begin
        if (en) begin
            x_dly_reg[0]  <= x_reg;
            y_dly_reg[0]  <= y_reg;
            for (int i = 1; i < XY_DLY; i++) begin
                x_dly_reg[i] <= x_dly_reg[i-1];
                y_dly_reg[i] <= y_dly_reg[i-1];
            end
            xy_dly_reg[0] <= xy;
            for (int i = 1; i < XYP_DLY; i++) begin
                xy_dly_reg[i] <= xy_dly_reg[i-1];
            end
            tx_dly_reg[0] <= tx_reg;
            ty_dly_reg[0] <= ty_reg;
            for (int i = 1; i < T_DLY; i++) begin
                tx_dly_reg[i] <= tx_dly_reg[i-1];
                ty_dly_reg[i] <= ty_dly_reg[i-1];
            end
            r2_dly_reg[0] <= r2_reg;
            for (int i = 1; i < R2_DLY; i++) begin
                r2_dly_reg[i] <= r2_dly_reg[i-1];
            end
            r4_dly_reg[0] <= r4;
            for (int i = 1; i < R4_DLY; i++) begin
                r4_dly_reg[i] <= r4_dly_reg[i-1];
            end
        end
    end

    // Radial factor
    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg <= sat_q(ONE_Q30 + ext64(k1r) + ext64(k2r) + ext64(k3r));
        end
    end

    // Second product layer: scale by the radial factor, tangential terms
    ldpm_mulq u_mul_xrad (.aclk, .en, .a(x_dly_reg[XY_DLY-1]), .b(rad_reg), .shift(SH_Q30),
                          .p(xrad));
    ldpm_mulq u_mul_yrad (.aclk, .en, .a(y_dly_reg[XY_DLY-1]), .b(rad_reg), .shift(SH_Q30),
                          .p(yrad));
    ldpm_mulq u_mul_p1xy (.aclk, .en, .a(p1), .b(xy_dly_reg[XYP_DLY-1]), .shift(SH_DBL),
                          .p(p1xy));
    ldpm_mulq u_mul_p2xy (.aclk, .en, .a(p2), .b(xy_dly_reg[XYP_DLY-1]), .shift(SH_DBL),
                          .p(p2xy));
    ldpm_mulq u_mul_p2tx (.aclk, .en, .a(p2), .b(tx_dly_reg[T_DLY-1]), .shift(SH_COEF),
                          .p(p2tx));
    ldpm_mulq u_mul_p1ty (.aclk, .en, .a(p1), .b(ty_dly_reg[T_DLY-1]), .shift(SH_COEF),
                          .p(p1ty));

    // Distorted normalised point
    always_ff @(posedge aclk) begin
        if (en) begin
            xd_reg <= sat_q(ext64(xrad) + ext64(p1xy) + ext64(p2tx));
            yd_reg <= sat_q(ext64(yrad) + ext64(p1ty) + ext64(p2xy));
        end
    end

    // Back to pixels
    ldpm_mulq u_mul_fx (.aclk, .en, .a(xd_reg), .b(fx_q), .shift(SH_Q30), .p(qx));
    ldpm_mulq u_mul_fy (.aclk, .en, .a(yd_reg), .b(fy_q), .shift(SH_Q30), .p(qy));

    // Add the principal point, round half up from Q.8 to whole pixels, saturate to 24 bits
    always_comb begin
        q8x = (ext64(qx) + signed'({32'b0, cx}) + 64'sd128) >>> 8;
        q8y = (ext64(qy) + signed'({32'b0, cy}) + 64'sd128) >>> 8;
        clip_x  = (q8x > OUT_MAX) || (q8x < OUT_MIN);
        clip_y  = (q8y > OUT_MAX) || (q8y < OUT_MIN);
        ox_next = (q8x > OUT_MAX) ? OUT_MAX[CW-1:0] :
                  (q8x < OUT_MIN) ? OUT_MIN[CW-1:0] : q8x[CW-1:0];
        oy_next = (q8y > OUT_MAX) ? OUT_MAX[CW-1:0] :
                  (q8y < OUT_MIN) ? OUT_MIN[CW-1:0] : q8y[CW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            clip_reg <= clip_x | clip_y;
        end
    end

    // Result channel
    assign m_tvalid = vld_reg[LATENCY-1];
    assign m_tlast  = last_reg[LATENCY-1];
    assign m_tdata  = {oy_reg, ox_reg};
    assign m_tuser  = clip_reg;

endmodule

// ----- test/tb_lens_distortion_point_map.sv -----
// Self-checking testbench of lens_distortion_point_map: directed and random points,
// several register settings, bursty sender and stalling receiver.
// Depends on ldpm_pkg and the lens_distortion_point_map RTL.
`timescale 1ns / 1ps

module tb_lens_distortion_point_map;
    import ldpm_pkg::*;

    localparam longint QL = 64'h0FFF_FFFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = LATENCY + 20;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic        last;
    } point_t;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic        last;
        logic        clip;
    } mapped_t;

    // directed stimulus row: point and optional typed-in result
    typedef struct {
        point_t  pt;
        bit      fixed;
        mapped_t res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    // predictor copy of the registers
    longint unsigned lens_fx, lens_fy, lens_pp;
    longint          lens_k1, lens_k2, lens_k3, lens_p1, lens_p2;

    mapped_t   expected_points[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    int        stall_mode = 0;
    stim_row_t dir_rows[$];

    lens_distortion_point_map u_top (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint clamp_q(longint v);
        if (v > QL) return QL;
        if (v < -QL) return -QL;
        return v;
    endfunction

    // exact product shifted right, truncated toward zero, saturated
    function automatic longint mul_shift(longint a, longint b, int s);
        logic [127:0] ua, ub, p;
        bit neg;
        longint r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 128'(-a) : 128'(a);
        ub = (b < 0) ? 128'(-b) : 128'(b);
        p = (ua * ub) >> s;
        r = (p > 128'(QL)) ? QL : longint'(p[63:0]);
        return neg ? -r : r;
    endfunction

    function automatic longint norm_coord(longint d, longint unsigned f);
        logic [127:0] m, q;
        longint r;
        m = (d < 0) ? 128'(-d) : 128'(d);
        q = ((m << 30) + 128'(f >> 1)) / 128'(f);
        r = (q > 128'(QL)) ? QL : longint'(q[63:0]);
        return (d < 0) ? -r : r;
    endfunction

    function automatic logic [23:0] to_q8(longint v, longint unsigned f, longint c,
                                          inout bit clip);
        longint q16, q8;
        q16 = mul_shift(v, longint'(f), 30) + c;
        q8 = (q16 + 128) >>> 8;
        if (q8 > 8388607) begin q8 = 8388607; clip = 1'b1; end
        if (q8 < -8388608) begin q8 = -8388608; clip = 1'b1; end
        return q8[23:0];
    endfunction

    function automatic mapped_t distort_point(point_t pt);
        longint unsigned fx, fy;
        longint cx, cy, x, y, xx, yy, xy, r2, r4, r6, rad, tx, ty, xd, yd;
        bit clip;
        mapped_t r;
        fx = (lens_fx == 0) ? 1 : lens_fx;
        fy = (lens_fy == 0) ? 1 : lens_fy;
        cx = longint'(lens_pp[31:0]);
        cy = longint'(lens_pp[63:32]);
        x = norm_coord(longint'($signed(pt.x)) * 256 - cx, fx);
        y = norm_coord(longint'($signed(pt.y)) * 256 - cy, fy);
        xx = mul_shift(x, x, 30);
        yy = mul_shift(y, y, 30);
        xy = mul_shift(x, y, 30);
        r2 = clamp_q(xx + yy);
        r4 = mul_shift(r2, r2, 30);
        r6 = mul_shift(r4, r2, 30);
        rad = clamp_q(64'sd1073741824 + mul_shift(lens_k1, r2, 24)
                      + mul_shift(lens_k2, r4, 24) + mul_shift(lens_k3, r6, 24));
        tx = clamp_q(r2 + 2 * xx);
        ty = clamp_q(r2 + 2 * yy);
        xd = clamp_q(mul_shift(x, rad, 30) + mul_shift(lens_p1, xy, 23)
                     + mul_shift(lens_p2, tx, 24));
        yd = clamp_q(mul_shift(y, rad, 30) + mul_shift(lens_p1, ty, 24)
                     + mul_shift(lens_p2, xy, 23));
        clip = 1'b0;
        r.x = to_q8(xd, fx, cx, clip);
        r.y = to_q8(yd, fy, cy, clip);
        r.last = pt.last;
        r.clip = clip;
        return r;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [63:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 6'(idx) << 3; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_FOCAL_X:   lens_fx = val[31:0];
            REG_FOCAL_Y:   lens_fy = val[31:0];
            REG_PRINCIPAL: lens_pp = val;
            REG_K1:        lens_k1 = longint'($signed(val[31:0]));
            REG_K2:        lens_k2 = longint'($signed(val[31:0]));
            REG_K3:        lens_k3 = longint'($signed(val[31:0]));
            REG_P1:        lens_p1 = longint'($signed(val[31:0]));
            REG_P2:        lens_p2 = longint'($signed(val[31:0]));
            default: ;
        endcase
    endtask

    task automatic load_lens(logic [31:0] fx, logic [31:0] fy, logic [63:0] pp,
                             logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
                             logic [31:0] p1, logic [31:0] p2);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_PRINCIPAL, pp);
        write_reg(REG_K1, k1);
        write_reg(REG_K2, k2);
        write_reg(REG_K3, k3);
        write_reg(REG_P1, p1);
        write_reg(REG_P2, p2);
    endtask

    // wait until every expected result has arrived, then let the pipe drain
    task automatic drain_pipe();
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // offer one point and hold it until accepted
    task automatic send_point(point_t pt, bit fixed, mapped_t res);
        mapped_t want;
        s_tvalid <= 1'b1;
        s_tdata <= {pt.y, pt.x};
        s_tlast <= pt.last;
        do @(posedge aclk); while (!s_tready);
        want = fixed ? res : distort_point(pt);
        expected_points.insert(expected_points.size(), want);
    endtask

    task automatic send_random(int n, int shape);
        point_t pt;
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && n > 0) begin
                case (shape)
                    0: begin
                        pt.x = 24'($urandom); pt.y = 24'($urandom);
                    end
                    default: begin
                        pt.x = 24'($signed($urandom_range(0, 8191)) - 4096);
                        pt.y = 24'($signed($urandom_range(0, 8191)) - 4096);
                    end
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    pt.x = 24'($urandom); pt.y = 24'($urandom);
                end
                pt.last = $urandom_range(0, 7) == 0;
                send_point(pt, 1'b0, '0);
                burst--; n--;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic add_row(logic [23:0] x, logic [23:0] y, bit last, bit fixed,
                           mapped_t res);
        stim_row_t r;
        r.pt = '{x, y, last};
        r.fixed = fixed;
        r.res = res;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // receiver stall pattern: phases of no stall, random and long stalls
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 2) != 0;
            default: m_tready <= $urandom_range(0, 9) == 0;
        endcase
    end

    // compare results with the oldest expected point; watchdog on idle cycles
    always @(posedge aclk) begin
        mapped_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[23:0], m_tdata[47:24], m_tlast, m_tuser[0]};
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_points.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp/got: x %h/%h y %h/%h last %b/%b clip %b/%b",
                                 want.x, got.x, want.y, got.y, want.last, got.last,
                                 want.clip, got.clip);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[lens_distortion_point_map] ERROR");
            $finish;
        end
    end

    initial begin
        mapped_t nr;
        lens_fx = 65536; lens_fy = 65536; lens_pp = 0;
        lens_k1 = 0; lens_k2 = 0; lens_k3 = 0; lens_p1 = 0; lens_p2 = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers: identity map, typed-in results but for the last point, which the predictor computes
        add_row(24'h000000, 24'h000000, 1'b0, 1'b1, '{24'h000000, 24'h000000, 1'b0, 1'b0});
        add_row(24'h7FFFFF, 24'h800000, 1'b1, 1'b1, '{24'h7FFFFF, 24'h800000, 1'b1, 1'b0});
        add_row(24'h800000, 24'h7FFFFF, 1'b0, 1'b1, '{24'h800000, 24'h7FFFFF, 1'b0, 1'b0});
        add_row(24'h000100, 24'hFFFF00, 1'b1, 1'b1, '{24'h000100, 24'hFFFF00, 1'b1, 1'b0});
        add_row(24'h123456, 24'hABCDEF, 1'b0, 1'b0, nr);
        foreach (dir_rows[i]) send_point(dir_rows[i].pt, dir_rows[i].fixed, dir_rows[i].res);
        s_tvalid <= 1'b0;
        drain_pipe();

        // zero focal lengths, huge coefficients: saturation and clipping
        load_lens(32'h0, 32'h0, 64'h0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                  32'h80000000, 32'h7FFFFFFF);
        dir_rows.delete();
        add_row(24'h000000, 24'h000000, 1'b0, 1'b0, nr);
        add_row(24'h000001, 24'hFFFFFF, 1'b1, 1'b0, nr);
        add_row(24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0, nr);
        add_row(24'h800000, 24'h800000, 1'b1, 1'b0, nr);
        foreach (dir_rows[i]) send_point(dir_rows[i].pt, dir_rows[i].fixed, dir_rows[i].res);
        s_tvalid <= 1'b0;
        drain_pipe();

        // maximum focal lengths and principal point
        load_lens(32'hFFFFFFFF, 32'hFFFFFFFF, 64'hFFFFFFFF_FFFFFFFF, 32'h00010000,
                  32'hFFFF0000, 32'h00000100, 32'h00001000, 32'hFFFFF000);
        send_random(100, 0);
        drain_pipe();

        // realistic camera: moderate focal lengths, small distortion
        load_lens(32'h0200_0000, 32'h01F0_0000, {32'h00F0_0000, 32'h0140_0000},
                  32'hFF80_0000, 32'h0020_0000, 32'hFFF0_0000, 32'h0000_8000,
                  32'hFFFF_4000);
        send_random(250, 1);
        drain_pipe();

        // random registers
        load_lens($urandom_range(65536, 32'h0400_0000), $urandom_range(65536, 32'h0400_0000),
                  {$urandom, $urandom}, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_random(350, 1);
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("[lens_distortion_point_map] OK");
        end else begin
            $display("[lens_distortion_point_map] ERROR");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/ldpm_pkg.sv
hdl/ldpm_mulq.sv
hdl/lens_distortion_point_map.sv
test/tb_lens_distortion_point_map.sv
